/* hdl/bsc_pkg.sv */
// bsc_pkg: shared types, constants and helpers for the barometric compensation core
// used by bsc_mul, bsc_div and barometric_sensor_compensation_core; no dependencies
`default_nettype none
package bsc_pkg;

  typedef logic signed [32:0] mul_op_t;
  typedef logic signed [65:0] mul_res_t;
  typedef logic signed [63:0] wide_t;

  localparam int unsigned DIV_W = 33;
  localparam int unsigned DEN_W = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TEMP = 6'b000010,
    S_PRE  = 6'b000100,
    S_DIV  = 6'b001000,
    S_POST = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  localparam wide_t C_FT_OFFSET = 64'sd64000;
  localparam wide_t C_ADC_FULL  = 64'sd1048576;
  localparam wide_t C_P1_ONE    = 64'sd32768;
  localparam logic [31:0] C_T_ROUND = 32'd128;
  localparam mul_op_t C_P_SCALE = 33'sd3125;
  localparam mul_op_t C_T_SCALE = 33'sd5;

  function automatic mul_op_t s16(input logic [15:0] v);
    return {{17{v[15]}}, v};
  endfunction

  function automatic mul_op_t u16(input logic [15:0] v);
    return {17'd0, v};
  endfunction

  function automatic wide_t sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // signed divide by 2^k, truncating toward zero
  function automatic wide_t sdiv_p2(input wide_t x, input int unsigned k);
    wide_t bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage
`default_nettype wire

/* hdl/barometric_sensor_compensation_core.sv */
// barometric_sensor_compensation_core: integer temperature and pressure compensation
// depends on bsc_pkg, bsc_mul, bsc_div
//
// usage:
//   input channel (in_valid/in_ready): in_mode selects temperature (0) or pressure (1),
//   in_raw_sample is the 20-bit converter reading. one transfer starts one item.
//   result channel (out_valid/out_ready): one result per item, out_kind echoes the mode.
//   config port: cfg_we writes cfg_wdata into coefficient register cfg_index
//   (0 temperature, 1..3 pressure groups); write only while the core is idle.
// sequencing:
//   temperature items run 7 multiplier steps and then the hand-off state S_DONE.
//   pressure items run 20 sequencer steps on the shared multiplier, the bit-serial
//   divider, 8 more multiplier steps and the hand-off state. a zero divisor skips
//   the divider and the later multiplier steps.
//   in_ready is high only while the sequencer is idle, one item at a time; the next
//   transfer can be taken in the same cycle in which out_valid rises.
// reset: synchronous active-low rst_n clears coefficients, fine temperature and
//   the valid flags.
// stall: a finished result sits in the output register; the next item is taken
//   meanwhile, and its result waits in the sequencer until the output drains.
`default_nettype none
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic [19:0]        in_raw_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_kind,
  output logic signed [31:0]      out_temperature,
  output logic        [31:0]      out_pressure,
  output logic                    out_divide_fault,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_wdata
);

  state_t      state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] temp_coeffs_r, press_a_r, press_b_r, press_c_r;
  logic [31:0] fine_r;

  logic        mode_r;
  logic [19:0] adc_r;
  wide_t       tmp_r, z_r, u_r, v1_r, q_r, v2_r;
  logic [31:0] pval_r;
  logic [32:0] p_r;
  logic signed [31:0] res_temp_r;
  logic [31:0] res_press_r;
  logic        res_fault_r;
  logic        out_kind_r, out_fault_r;
  logic signed [31:0] out_temp_r;
  logic [31:0] out_press_r;

  mul_op_t     mul_a, mul_b;
  mul_res_t    mul_prod;
  wide_t       prod64, prod_hi, prod_lo32;
  logic        div_start;
  logic [32:0] div_num, div_quo;
  div_stat_t   div_stat;

  mul_op_t     t_a, t_b;
  wide_t       t_sum;
  logic [31:0] t_round;
  logic        accept, out_free, last_step;

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs_r[15:0];
  assign t2 = temp_coeffs_r[31:16];
  assign t3 = temp_coeffs_r[47:32];
  assign p1 = press_a_r[15:0];
  assign p2 = press_a_r[31:16];
  assign p3 = press_a_r[47:32];
  assign p4 = press_b_r[15:0];
  assign p5 = press_b_r[31:16];
  assign p6 = press_b_r[47:32];
  assign p7 = press_c_r[15:0];
  assign p8 = press_c_r[31:16];
  assign p9 = press_c_r[47:32];

  bsc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  bsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (z_r[31:0]),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign prod64    = mul_prod[63:0];
  assign prod_hi   = {mul_prod[31:0], 32'd0};
  assign prod_lo32 = sx32(mul_prod[31:0]);

  assign t_a     = $signed({16'd0, adc_r[19:3]}) - $signed({16'd0, t1, 1'b0});
  assign t_b     = $signed({17'd0, adc_r[19:4]}) - $signed({17'd0, t1});
  assign t_sum   = tmp_r + (prod_lo32 >>> 14);
  assign t_round = mul_prod[31:0] + C_T_ROUND;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign div_num   = pval_r[31] ? {1'b0, pval_r} : {pval_r, 1'b0};
  assign div_start = (state_r == S_PRE) && (step_r == 5'd19) && (z_r[31:0] != 32'd0);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TEMP: begin
        case (step_r)
          5'd0: begin mul_a = t_a; mul_b = s16(t2); end
          5'd1: begin mul_a = t_b; mul_b = t_b; end
          5'd3: begin mul_a = z_r[32:0]; mul_b = s16(t3); end
          5'd5: begin mul_a = tmp_r[32:0]; mul_b = C_T_SCALE; end
          default: ;
        endcase
      end
      S_PRE: begin
        case (step_r)
          5'd2:  begin mul_a = tmp_r[32:0]; mul_b = tmp_r[32:0]; end
          5'd4:  begin mul_a = {1'b0, q_r[42:11]}; mul_b = s16(p6); end
          5'd5:  begin mul_a = {12'd0, q_r[63:43]}; mul_b = s16(p6); end
          5'd6:  begin mul_a = v1_r[32:0]; mul_b = s16(p5); end
          5'd8:  begin mul_a = {1'b0, q_r[44:13]}; mul_b = s16(p3); end
          5'd9:  begin mul_a = {14'd0, q_r[63:45]}; mul_b = s16(p3); end
          5'd10: begin mul_a = v1_r[32:0]; mul_b = s16(p2); end
          5'd11: begin mul_a = {1'b0, u_r[31:0]}; mul_b = C_P_SCALE; end
          5'd15: begin mul_a = {1'b0, tmp_r[31:0]}; mul_b = u16(p1); end
          5'd16: begin mul_a = {tmp_r[63], tmp_r[63:32]}; mul_b = u16(p1); end
          default: ;
        endcase
      end
      S_POST: begin
        case (step_r)
          5'd0: begin mul_a = {3'd0, p_r[32:3]}; mul_b = {3'd0, p_r[32:3]}; end
          5'd2: begin mul_a = tmp_r[32:0]; mul_b = s16(p9); end
          5'd3: begin mul_a = {2'd0, p_r[32:2]}; mul_b = s16(p8); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    last_step = 1'b0;
    unique case (state_r)
      S_TEMP:  last_step = (step_r == 5'd6);
      S_POST:  last_step = (step_r == 5'd7);
      default: last_step = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r + 5'd1;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          state_nxt = in_mode ? S_PRE : S_TEMP;
        end
      end
      S_TEMP: begin
        if (last_step) begin
          state_nxt = S_DONE;
        end
      end
      S_PRE: begin
        if (step_r == 5'd19) begin
          state_nxt = div_start ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        step_nxt = '0;
        if (div_stat.done) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (last_step) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        step_nxt = '0;
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
      fine_r        <= '0;
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_c_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if ((state_r == S_TEMP) && (step_r == 5'd4)) begin
        fine_r <= t_sum[31:0];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TEMP:    temp_coeffs_r <= cfg_wdata;
          REG_PRESS_A: press_a_r     <= cfg_wdata;
          REG_PRESS_B: press_b_r     <= cfg_wdata;
          REG_PRESS_C: press_c_r     <= cfg_wdata;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      adc_r  <= in_raw_sample;
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      p_r <= pval_r[31] ? {div_quo[31:0], 1'b0} : div_quo;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_kind_r  <= mode_r;
      out_temp_r  <= res_temp_r;
      out_press_r <= res_press_r;
      out_fault_r <= res_fault_r;
    end
    unique case (state_r)
      S_TEMP: begin
        case (step_r)
          5'd1: tmp_r <= prod_lo32 >>> 11;
          5'd2: z_r   <= prod_lo32 >>> 12;
          5'd4: tmp_r <= sx32(t_sum[31:0]);
          5'd6: begin
            res_temp_r  <= $signed(t_round) >>> 8;
            res_press_r <= '0;
            res_fault_r <= 1'b0;
          end
          default: ;
        endcase
      end
      S_PRE: begin
        case (step_r)
          5'd0:  v1_r  <= sdiv_p2(sx32(fine_r), 1) - C_FT_OFFSET;
          5'd1:  tmp_r <= sdiv_p2(v1_r, 2);
          5'd3:  q_r   <= prod64;
          5'd5:  v2_r  <= prod64;
          5'd6:  v2_r  <= v2_r + prod_hi;
          5'd7:  v2_r  <= v2_r + (prod64 <<< 1);
          5'd8:  v2_r  <= sdiv_p2(v2_r, 2) + (sx32({{16{p4[15]}}, p4}) <<< 16);
          5'd9: begin
            tmp_r <= prod64;
            u_r   <= sdiv_p2(v2_r, 12);
          end
          5'd10: begin
            tmp_r <= tmp_r + prod_hi;
            u_r   <= C_ADC_FULL - $signed({44'd0, adc_r}) - u_r;
          end
          5'd11: begin
            tmp_r <= sdiv_p2(tmp_r, 3);
            z_r   <= sdiv_p2(prod64, 1);
          end
          5'd12: begin
            tmp_r  <= tmp_r + z_r;
            pval_r <= mul_prod[31:0];
          end
          5'd13: tmp_r <= sdiv_p2(tmp_r, 18);
          5'd14: tmp_r <= tmp_r + C_P1_ONE;
          5'd16: z_r   <= prod64;
          5'd17: z_r   <= z_r + prod_hi;
          5'd18: z_r   <= sdiv_p2(z_r, 15);
          5'd19: begin
            res_temp_r  <= '0;
            res_press_r <= '0;
            res_fault_r <= (z_r[31:0] == 32'd0);
          end
          default: ;
        endcase
      end
      S_POST: begin
        case (step_r)
          5'd1: tmp_r <= sx32(mul_prod[44:13]);
          5'd3: tmp_r <= sdiv_p2(prod_lo32, 12);
          5'd4: z_r   <= sdiv_p2(prod_lo32, 13);
          5'd5: tmp_r <= tmp_r + z_r + sx32({{16{p7[15]}}, p7});
          5'd6: tmp_r <= sdiv_p2(tmp_r, 4);
          5'd7: begin
            res_temp_r  <= '0;
            res_press_r <= p_r[31:0] + tmp_r[31:0];
            res_fault_r <= 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_temperature  = out_temp_r;
  assign out_pressure     = out_press_r;
  assign out_divide_fault = out_fault_r;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("sequencer took no item");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (z_r[31:0] != 32'd0)) else $error("divide started on zero");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on idle divider");
  a_temp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |-> ((out_press_r == '0) && !out_fault_r))
    else $error("temperature result carries pressure fields");

endmodule
`default_nettype wire

/* hdl/bsc_mul.sv */
// bsc_mul: shared signed 33x33 multiplier with registered product
// depends on bsc_pkg
`default_nettype none
module bsc_mul
  import bsc_pkg::*;
(
  input  wire logic    clk,
  input  wire mul_op_t op_a,
  input  wire mul_op_t op_b,
  output mul_res_t     prod
);

  mul_res_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_res_t'(op_a) * mul_res_t'(op_b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

/* hdl/bsc_div.sv */
// bsc_div: restoring unsigned divider, one quotient bit per cycle
// depends on bsc_pkg
`default_nettype none
module bsc_div
  import bsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  output logic      [DIV_W-1:0]   quo,
  output div_stat_t               stat
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W-1:0] shifted;
  logic             fits;

  assign shifted = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, den_r}) : shifted;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (den_r != '0)) else $error("divider running on zero divisor");

endmodule
`default_nettype wire
